/* hdl/e2q_pkg.sv */
// Package for the euler_to_quaternion block: shared constants, the CORDIC
// arctangent table and a rounding multiply helper. No dependencies.
`default_nettype none
package e2q_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 7;
   localparam int OUT_FRAC_BITS_DEF   = 14;
   localparam int CORDIC_STAGES_DEF   = 16;

   localparam int WORK_FRAC = 30;
   // CORDIC datapath: Q30 values stay within about +-1.65
   localparam int CW = 33;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef logic signed [CW-1:0] work_type;
   typedef logic signed [32:0]   zang_type;

   function automatic logic [31:0] arc_at(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;  default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   // Q30 x Q30 product rounded back to Q30
   function automatic work_type qmul(input work_type a, input work_type b);
      logic signed [2*CW-1:0] p;
      p = a * b + (66'sd1 <<< (WORK_FRAC-1));
      return work_type'(p >>> WORK_FRAC);
   endfunction

endpackage
`default_nettype wire

/* hdl/e2q_angle.sv */
// Angle front end: saturate, halve and scale degrees to a 32-bit binary angle,
// then fold quadrants. Uses e2q_pkg. Two register stages.
`default_nettype none
module e2q_angle
   import e2q_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic signed [ANGLE_FRAC_BITS+9:0] angle,
   output      zang_type                      z_out,
   output      logic                          flip_out
);
   localparam int AW = ANGLE_FRAC_BITS + 10;
   localparam longint LIMIT = 64'd360 << ANGLE_FRAC_BITS;
   // q = round(mag * 2^31 / LIMIT) via reciprocal: (mag*RECIP + half) >> RS.
   // 2^RS exceeds LIMIT/2, so the estimate is at most one too high; the
   // remainder check below takes that one off.
   localparam int RS = ANGLE_FRAC_BITS + 9;
   localparam longint RECIP = ((64'd1 << (31 + RS)) / LIMIT) + 1;
   localparam longint RND = 64'd1 << (RS - 1);
   localparam int MW = AW;

   logic [MW-1:0]    mag_ff, mag_in;
   logic [MW+31:0]   prod_ff, prod_in;
   logic             neg_ff, neg_in;
   zang_type         z_ff, z_in;
   logic             flip_ff, flip_in;

   always_comb begin
      logic signed [AW:0] a;
      a = angle;
      if (a > $signed((AW+1)'(LIMIT))) a = (AW+1)'(LIMIT);
      if (a < -$signed((AW+1)'(LIMIT))) a = -(AW+1)'(LIMIT);
      neg_in  = a[AW];
      mag_in  = MW'(neg_in ? -a : a);
      prod_in = (MW+32)'(mag_in) * (MW+32)'(RECIP);
   end

   always_comb begin
      logic [63:0] num, q, chk, h;
      logic [31:0] u;
      // round-half-away: floor((2*mag*2^31 + LIMIT) / (2*LIMIT))
      num = (64'(mag_ff) << 32) + 64'(LIMIT);
      q   = 64'((prod_ff + (MW+32)'(RND)) >> RS);
      chk = q * 64'(2 * LIMIT);
      if (chk > num) q = q - 64'd1;
      h = neg_ff ? -q : q;
      u = h[31:0];
      flip_in = (u[31:30] == 2'b01) || (u[31:30] == 2'b10);
      if (flip_in) u = u - 32'h80000000;
      z_in = zang_type'($signed(u));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff  <= mag_in;
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
         z_ff    <= z_in;
         flip_ff <= flip_in;
      end
   end

   assign z_out    = z_ff;
   assign flip_out = flip_ff;
endmodule
`default_nettype wire

/* hdl/e2q_cordic_cell.sv */
// One CORDIC rotation cell: one micro-rotation per cycle while enabled, registered.
// Uses e2q_pkg for the data types and arctangent table.
`default_nettype none
module e2q_cordic_cell
   import e2q_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  wire logic     clock,
   input  wire logic     enable,
   input  wire work_type x_i,
   input  wire work_type y_i,
   input  wire zang_type z_i,
   input  wire logic     f_i,
   output      work_type x_o,
   output      work_type y_o,
   output      zang_type z_o,
   output      logic     f_o
);
   work_type x_ff, y_ff, x_in, y_in;
   zang_type z_ff, z_in;
   logic     f_ff;

   always_comb begin
      work_type dx, dy;
      zang_type at;
      dx = y_i >>> STAGE;
      dy = x_i >>> STAGE;
      at = zang_type'({1'b0, arc_at(5'(STAGE))});
      if (!z_i[32]) begin
         x_in = x_i - dx; y_in = y_i + dy; z_in = z_i - at;
      end else begin
         x_in = x_i + dx; y_in = y_i - dy; z_in = z_i + at;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; f_ff <= f_i;
      end
   end

   assign x_o = x_ff; assign y_o = y_ff; assign z_o = z_ff; assign f_o = f_ff;
endmodule
`default_nettype wire

/* hdl/e2q_trig.sv */
// Half-angle sine/cosine: angle front end, a row of CORDIC cells, a sign stage.
// Uses e2q_pkg, e2q_angle and e2q_cordic_cell.
`default_nettype none
module e2q_trig
   import e2q_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic signed [ANGLE_FRAC_BITS+9:0] angle,
   output      work_type                          sin_o,
   output      work_type                          cos_o
);
   work_type x [CORDIC_STAGES+1];
   work_type y [CORDIC_STAGES+1];
   zang_type z [CORDIC_STAGES+1];
   logic     f [CORDIC_STAGES+1];
   work_type s_ff, c_ff;

   e2q_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_angle (
      .clock(clock), .enable(enable), .angle(angle),
      .z_out(z[0]), .flip_out(f[0])
   );
   assign x[0] = CORDIC_GAIN;
   assign y[0] = '0;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      e2q_cordic_cell #(.STAGE(i)) u_cell (
         .clock(clock), .enable(enable),
         .x_i(x[i]), .y_i(y[i]), .z_i(z[i]), .f_i(f[i]),
         .x_o(x[i+1]), .y_o(y[i+1]), .z_o(z[i+1]), .f_o(f[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff <= f[CORDIC_STAGES] ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];
         c_ff <= f[CORDIC_STAGES] ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
      end
   end

   assign sin_o = s_ff;
   assign cos_o = c_ff;
endmodule
`default_nettype wire

/* hdl/euler_to_quaternion.sv */
// Euler angles (roll, pitch, yaw in fixed-point degrees) to quaternion.
// Depends on e2q_pkg, e2q_trig and its cells.
//
// Usage: present roll/pitch/yaw on req_* with req_valid; a transaction is
// taken when req_valid and req_ready are both high. The quaternion appears
// on rsp_quat_* with rsp_valid and is handed over when rsp_ready is high.
// Throughput: one transaction per cycle, sustained while the receiver does not stall.
// Pipeline: 2 angle-scaling stages, one cell per CORDIC micro-rotation, a
// sign stage, 2 pair-product stages, 2 triple-product stages and a sum/round
// stage. Pair products use four multiplies, triple products eight.
// The pipeline is one shift line with a valid bit per stage; it advances
// whenever the final stage is empty or being drained, so a stalled receiver
// freezes the whole line and req_ready falls until it drains.
// Reset clears all valid bits; no transaction survives it.
// Angles beyond +-360 degrees saturate; components saturate to +-1.
`default_nettype none
module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS   = OUT_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic signed [ANGLE_FRAC_BITS+9:0] req_roll_angle,
   input  wire logic signed [ANGLE_FRAC_BITS+9:0] req_pitch_angle,
   input  wire logic signed [ANGLE_FRAC_BITS+9:0] req_yaw_angle,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic signed [OUT_FRAC_BITS+1:0]   rsp_quat_x,
   output      logic signed [OUT_FRAC_BITS+1:0]   rsp_quat_y,
   output      logic signed [OUT_FRAC_BITS+1:0]   rsp_quat_z,
   output      logic signed [OUT_FRAC_BITS+1:0]   rsp_quat_w
);
   localparam int DEPTH = CORDIC_STAGES + 8;
   localparam int QW    = OUT_FRAC_BITS + 2;
   localparam int RSH   = WORK_FRAC - OUT_FRAC_BITS;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             advance;

   // whole line moves when the output slot is free or being taken
   assign advance   = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   work_type sx, cx, sy, cy, sz, cz;

   e2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
      .clock(clock), .enable(advance), .angle(req_roll_angle), .sin_o(sx), .cos_o(cx));
   e2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
      .clock(clock), .enable(advance), .angle(req_pitch_angle), .sin_o(sy), .cos_o(cy));
   e2q_trig #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
      .clock(clock), .enable(advance), .angle(req_yaw_angle), .sin_o(sz), .cos_o(cz));

   // pair products of roll and pitch: cx*cy, sx*sy, sx*cy, cx*sy; each is
   // rounded before the yaw term is applied
   work_type cc_ff, ss_ff, sc_ff, cs_ff;
   work_type sz1_ff, cz1_ff;
   work_type sz2_ff, cz2_ff, cc2_ff, ss2_ff, sc2_ff, cs2_ff;
   work_type t0_ff, t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff;
   work_type u0_ff, u1_ff, u2_ff, u3_ff, u4_ff, u5_ff, u6_ff, u7_ff;
   logic signed [QW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;

   function automatic logic signed [QW-1:0] fin(input work_type a, input work_type b,
                                               input logic sub);
      logic signed [CW+1:0] s, one;
      s   = sub ? (CW+2)'(a) - (CW+2)'(b) : (CW+2)'(a) + (CW+2)'(b);
      s   = (s + ((CW+2)'(1) <<< (RSH-1))) >>> RSH;
      one = (CW+2)'(1) <<< OUT_FRAC_BITS;
      if (s > one) s = one;
      if (s < -one) s = -one;
      return QW'(s);
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         cc_ff <= qmul(cx, cy); ss_ff <= qmul(sx, sy);
         sc_ff <= qmul(sx, cy); cs_ff <= qmul(cx, sy);
         sz1_ff <= sz; cz1_ff <= cz;
         sz2_ff <= sz1_ff; cz2_ff <= cz1_ff;
         cc2_ff <= cc_ff; ss2_ff <= ss_ff; sc2_ff <= sc_ff; cs2_ff <= cs_ff;
         t0_ff <= qmul(sc2_ff, cz2_ff); t1_ff <= qmul(cs2_ff, sz2_ff);
         t2_ff <= qmul(cs2_ff, cz2_ff); t3_ff <= qmul(sc2_ff, sz2_ff);
         t4_ff <= qmul(cc2_ff, sz2_ff); t5_ff <= qmul(ss2_ff, cz2_ff);
         t6_ff <= qmul(cc2_ff, cz2_ff); t7_ff <= qmul(ss2_ff, sz2_ff);
         u0_ff <= t0_ff; u1_ff <= t1_ff; u2_ff <= t2_ff; u3_ff <= t3_ff;
         u4_ff <= t4_ff; u5_ff <= t5_ff; u6_ff <= t6_ff; u7_ff <= t7_ff;
         qx_ff <= fin(u0_ff, u1_ff, 1'b0);
         qy_ff <= fin(u2_ff, u3_ff, 1'b1);
         qz_ff <= fin(u4_ff, u5_ff, 1'b0);
         qw_ff <= fin(u6_ff, u7_ff, 1'b1);
      end
   end

   assign rsp_valid  = vld_ff[DEPTH-1];
   assign rsp_quat_x = qx_ff;
   assign rsp_quat_y = qy_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

   // a stalled result must not be overwritten
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_w))
      else $error("result changed while stalled");
   // w component within +-1
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= (QW'(1) <<< OUT_FRAC_BITS)
                 && rsp_quat_w >= -(QW'(1) <<< OUT_FRAC_BITS))
      else $error("component out of range");
   // line frozen while stalled
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
endmodule
`default_nettype wire
